[rtl/core/hsvrgb_pkg.sv]
// Shared constants and the hue sector type for the HSV to RGB converter.
package hsvrgb_pkg;

	localparam int CHANNEL_BITS_DEF  = 8;
	localparam int HUE_FRAC_BITS_DEF = 6;
	localparam int HUE_BITS          = 16;
	localparam int HUE_MAG_BITS      = HUE_BITS - 1;

	// 60-degree sectors, named by which channel gets chroma and which gets X
	typedef enum logic [2:0] {
		SEC_RG = 3'd0,
		SEC_GR = 3'd1,
		SEC_GB = 3'd2,
		SEC_BG = 3'd3,
		SEC_BR = 3'd4,
		SEC_RB = 3'd5
	} sector_t;

endpackage

[rtl/core/hsvrgb_hue.sv]
// Hue reduction pipeline: wraps hue to one turn, then splits it into sector and fraction.
module hsvrgb_hue #(
	parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF,
	parameter int FRAC_W        = $clog2((60 << HUE_FRAC_BITS) + 1)
) (
	input  logic                                 clk,
	input  logic [hsvrgb_pkg::HUE_MAG_BITS-1:0] hue_mag,
	output hsvrgb_pkg::sector_t                  sector_s3,
	output logic [FRAC_W-1:0]                    frac_s3
);
	import hsvrgb_pkg::*;

	localparam int SECTOR = 60 << HUE_FRAC_BITS;
	localparam int TURN   = 6 * SECTOR;
	localparam int TL     = $clog2(TURN);
	localparam int TSH    = HUE_MAG_BITS + TL;
	localparam logic [63:0] TK = ((64'd1 << TSH) + 64'(TURN) - 64'd1) / 64'(TURN);
	localparam int TKW    = $clog2(TK + 64'd1);
	localparam int TPW    = HUE_MAG_BITS + TKW;

	logic [HUE_MAG_BITS-1:0] h_s1;
	logic [TPW-1:0]          tp_s1;
	logic [HUE_MAG_BITS-1:0] turns;
	logic [31:0]             turn_span;
	logic [HUE_MAG_BITS-1:0] hp_s2;
	sector_t                 sec_c;
	logic [31:0]             rem_c;
	logic [31:0]             frac_c;

	// Stage 1: reciprocal multiply for the number of whole turns
	always_ff @(posedge clk) begin
		h_s1  <= hue_mag;
		tp_s1 <= TPW'(hue_mag) * TPW'(TK[TKW-1:0]);
	end

	// Stage 2: remove whole turns
	assign turns     = HUE_MAG_BITS'(tp_s1 >> TSH);
	assign turn_span = 32'(turns) * 32'(TURN);

	always_ff @(posedge clk) begin
		hp_s2 <= h_s1 - turn_span[HUE_MAG_BITS-1:0];
	end

	// Stage 3: pick the highest sector boundary not above the wrapped hue
	always_comb begin
		sec_c = SEC_RG;
		rem_c = 32'(hp_s2);
		for (int k = 1; k < 6; k++) begin
			if (32'(hp_s2) >= 32'(k * SECTOR)) begin
				sec_c = sector_t'(3'(k));
				rem_c = 32'(hp_s2) - 32'(k * SECTOR);
			end
		end
		frac_c = sec_c[0] ? (32'(SECTOR) - rem_c) : rem_c;
	end

	always_ff @(posedge clk) begin
		sector_s3 <= sec_c;
		frac_s3   <= FRAC_W'(frac_c);
	end

endmodule

[rtl/core/hsv_to_rgb_core.sv]
// HSV to RGB pixel converter, top level.
// Takes one pixel per clock whenever start is high; busy is always low since the
// pipeline never stalls. Each result is shown with done high for a single cycle.
// The six register stages are: V times S and the turn-count multiply, chroma
// divide and hue wrap, sector split, X multiply, X reciprocal divide, channel
// mux and add. The receiver cannot hold results off.
// A negative hue gives gray at V - C.
module hsv_to_rgb_core #(
	parameter int CHANNEL_BITS  = hsvrgb_pkg::CHANNEL_BITS_DEF,
	parameter int HUE_FRAC_BITS = hsvrgb_pkg::HUE_FRAC_BITS_DEF
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     start,
	output logic                                     busy,
	input  logic signed [hsvrgb_pkg::HUE_BITS-1:0]   hue,
	input  logic [CHANNEL_BITS-1:0]                  saturation,
	input  logic [CHANNEL_BITS-1:0]                  value,
	output logic                                     done,
	output logic [CHANNEL_BITS-1:0]                  red,
	output logic [CHANNEL_BITS-1:0]                  green,
	output logic [CHANNEL_BITS-1:0]                  blue
);
	import hsvrgb_pkg::*;

	localparam int N       = CHANNEL_BITS;
	localparam int SECTOR  = 60 << HUE_FRAC_BITS;
	localparam int FRAC_W  = $clog2(SECTOR + 1);
	localparam int SHIFT_A = HUE_FRAC_BITS + 2;
	localparam int YW      = N + 4;
	localparam int DSH     = YW + 4;
	localparam logic [63:0] DK = ((64'd1 << DSH) + 64'd14) / 64'd15;
	localparam int DKW     = $clog2(DK + 64'd1);
	localparam int DPW     = YW + DKW;
	localparam int XPW     = N + FRAC_W;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic [2*N-1:0] p_s1;
	logic [N-1:0]   v_s1;
	logic           neg_s1;

	logic [2*N:0]   chroma_sum;
	logic [N-1:0]   c_s2, m_s2;
	logic           neg_s2;

	logic [N-1:0]   c_s3, m_s3;
	logic           neg_s3;
	sector_t        sector_s3;
	logic [FRAC_W-1:0] frac_s3;

	logic [XPW-1:0] xprod;
	logic [YW-1:0]  y_s4;
	logic [N-1:0]   c_s4, m_s4;
	logic           neg_s4;
	sector_t        sector_s4;

	logic [DPW-1:0] dp_s5;
	logic [N-1:0]   c_s5, m_s5;
	logic           neg_s5;
	sector_t        sector_s5;

	logic [N-1:0]   x_c, r_c, g_c, b_c;
	logic [N-1:0]   red_s6, green_s6, blue_s6;

	assign busy = 1'b0;

	// Valid bits advance with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	hsvrgb_hue #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.FRAC_W        (FRAC_W)
	) u_hue (
		.clk       (clk),
		.hue_mag   (hue[HUE_MAG_BITS-1:0]),
		.sector_s3 (sector_s3),
		.frac_s3   (frac_s3)
	);

	// Stage 1: V * S
	always_ff @(posedge clk) begin
		p_s1   <= (2*N)'(saturation) * (2*N)'(value);
		v_s1   <= value;
		neg_s1 <= hue[HUE_BITS-1];
	end

	// Stage 2: exact divide by all-ones: (p + (p >> N) + 1) >> N
	assign chroma_sum = (2*N+1)'(p_s1) + (2*N+1)'(p_s1 >> N) + (2*N+1)'(1);

	always_ff @(posedge clk) begin
		c_s2   <= chroma_sum[2*N-1:N];
		m_s2   <= v_s1 - chroma_sum[2*N-1:N];
		neg_s2 <= neg_s1;
	end

	// Stage 3: wait for the hue split
	always_ff @(posedge clk) begin
		c_s3   <= c_s2;
		m_s3   <= m_s2;
		neg_s3 <= neg_s2;
	end

	// Stage 4: C * f, drop the power-of-two part of the sector size
	assign xprod = XPW'(c_s3) * XPW'(frac_s3);

	always_ff @(posedge clk) begin
		y_s4      <= YW'(xprod >> SHIFT_A);
		c_s4      <= c_s3;
		m_s4      <= m_s3;
		neg_s4    <= neg_s3;
		sector_s4 <= sector_s3;
	end

	// Stage 5: reciprocal multiply for the divide by 15
	always_ff @(posedge clk) begin
		dp_s5     <= DPW'(y_s4) * DPW'(DK[DKW-1:0]);
		c_s5      <= c_s4;
		m_s5      <= m_s4;
		neg_s5    <= neg_s4;
		sector_s5 <= sector_s4;
	end

	// Stage 6: place C and X, add M
	assign x_c = N'(dp_s5 >> DSH);

	always_comb begin
		r_c = '0;
		g_c = '0;
		b_c = '0;
		if (!neg_s5) begin
			case (sector_s5)
				SEC_RG: begin r_c = c_s5; g_c = x_c; end
				SEC_GR: begin r_c = x_c; g_c = c_s5; end
				SEC_GB: begin g_c = c_s5; b_c = x_c; end
				SEC_BG: begin g_c = x_c; b_c = c_s5; end
				SEC_BR: begin r_c = x_c; b_c = c_s5; end
				default: begin r_c = c_s5; b_c = x_c; end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		red_s6   <= r_c + m_s5;
		green_s6 <= g_c + m_s5;
		blue_s6  <= b_c + m_s5;
	end

	assign done  = vld_s6;
	assign red   = red_s6;
	assign green = green_s6;
	assign blue  = blue_s6;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##6 done)
		else $error("result strobe missing six cycles after transfer");

	a_gray_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(start && hue[HUE_BITS-1]) |-> ##6 (red == green && green == blue))
		else $error("negative hue did not give gray");

	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(start && saturation == '0) |-> ##6
		(red == $past(value, 6) && green == $past(value, 6) && blue == $past(value, 6)))
		else $error("zero saturation did not give value on all channels");

	a_max_is_v: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !hue[HUE_BITS-1]) |-> ##6
		(red == $past(value, 6) || green == $past(value, 6) || blue == $past(value, 6)))
		else $error("no channel carries the value");

endmodule

[bench/testbench.sv]
// Self-checking testbench for the HSV to RGB pixel converter.
`timescale 1ns / 100ps

module testbench;
	import hsvrgb_pkg::*;

	localparam int CHAN_BITS      = CHANNEL_BITS_DEF;
	localparam int CHAN_MAX       = (1 << CHAN_BITS) - 1;
	localparam int SECTOR_SIZE    = 60 << HUE_FRAC_BITS_DEF;
	localparam int TURN_SIZE      = 6 * SECTOR_SIZE;
	localparam int RANDOM_PIXELS  = 1900;
	localparam int DRAIN_CYCLES   = 12;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct {
		logic signed [HUE_BITS-1:0] hue;
		logic [CHAN_BITS-1:0]       sat;
		logic [CHAN_BITS-1:0]       val;
		int                         idle_pct;
	} hsv_pixel_t;

	typedef struct {
		logic [CHAN_BITS-1:0] red;
		logic [CHAN_BITS-1:0] green;
		logic [CHAN_BITS-1:0] blue;
	} rgb_pixel_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       start = 1'b0;
	logic                       busy;
	logic signed [HUE_BITS-1:0] hue = '0;
	logic [CHAN_BITS-1:0]       saturation = '0;
	logic [CHAN_BITS-1:0]       value = '0;
	logic                       done;
	logic [CHAN_BITS-1:0]       red;
	logic [CHAN_BITS-1:0]       green;
	logic [CHAN_BITS-1:0]       blue;

	hsv_pixel_t pixel_queue[$];
	rgb_pixel_t rgb_expected[$];
	int         error_count = 0;
	int         pixels_sent = 0;
	int         results_seen = 0;
	int         gray_count = 0;
	int         wrap_count = 0;
	int         quiet_cycles = 0;

	hsv_to_rgb_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.hue        (hue),
		.saturation (saturation),
		.value      (value),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic rgb_pixel_t convert_hsv(logic signed [HUE_BITS-1:0] h,
			logic [CHAN_BITS-1:0] s, logic [CHAN_BITS-1:0] v);
		rgb_pixel_t px;
		int hv;
		int chroma;
		int gray;
		int wrapped;
		int rem;
		int frac;
		int x;
		int r;
		int g;
		int b;
		sector_t sec;
		hv = int'(h);
		chroma = (int'(v) * int'(s)) / CHAN_MAX;
		gray = int'(v) - chroma;
		r = 0;
		g = 0;
		b = 0;
		if (hv >= 0) begin
			wrapped = hv % TURN_SIZE;
			sec = sector_t'(wrapped / SECTOR_SIZE);
			rem = wrapped % SECTOR_SIZE;
			frac = (sec[0]) ? SECTOR_SIZE - rem : rem;
			x = (chroma * frac) / SECTOR_SIZE;
			case (sec)
				SEC_RG: begin r = chroma; g = x; end
				SEC_GR: begin r = x; g = chroma; end
				SEC_GB: begin g = chroma; b = x; end
				SEC_BG: begin g = x; b = chroma; end
				SEC_BR: begin r = x; b = chroma; end
				default: begin r = chroma; b = x; end
			endcase
		end
		px.red   = CHAN_BITS'(r + gray);
		px.green = CHAN_BITS'(g + gray);
		px.blue  = CHAN_BITS'(b + gray);
		return px;
	endfunction

	// Driver: record the transfer seen at this edge, then present the next pixel.
	always @(posedge clk) begin
		if (start && !busy) begin
			rgb_expected.push_back(convert_hsv(hue, saturation, value));
			pixels_sent++;
			if (hue < 0)
				gray_count++;
			else if (int'(hue) >= TURN_SIZE)
				wrap_count++;
		end
		if (arst_n && pixel_queue.size() > 0 && !(start && busy) &&
				$urandom_range(99) >= pixel_queue[0].idle_pct) begin
			start      <= 1'b1;
			hue        <= pixel_queue[0].hue;
			saturation <= pixel_queue[0].sat;
			value      <= pixel_queue[0].val;
			void'(pixel_queue.pop_front());
		end else if (!(start && busy)) begin
			start <= 1'b0;
		end
	end

	// Monitor: every strobed result must match the oldest expected pixel.
	always @(posedge clk) begin
		if (arst_n && done) begin
			results_seen++;
			if (rgb_expected.size() == 0) begin
				$display("%0t: unexpected result r=%0d g=%0d b=%0d", $time, red, green, blue);
				error_count++;
			end else begin
				if (red !== rgb_expected[0].red) begin
					$display("%0t: red expected %0d, got %0d", $time,
						rgb_expected[0].red, red);
					error_count++;
				end
				if (green !== rgb_expected[0].green) begin
					$display("%0t: green expected %0d, got %0d", $time,
						rgb_expected[0].green, green);
					error_count++;
				end
				if (blue !== rgb_expected[0].blue) begin
					$display("%0t: blue expected %0d, got %0d", $time,
						rgb_expected[0].blue, blue);
					error_count++;
				end
				void'(rgb_expected.pop_front());
			end
		end
	end

	// Watchdog: count cycles with neither a transfer nor a result.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired with %0d results outstanding", $time,
				rgb_expected.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic hsv_pixel_t make_pixel(int h, int s, int v, int pct);
		hsv_pixel_t px;
		px.hue      = HUE_BITS'(h);
		px.sat      = CHAN_BITS'(s);
		px.val      = CHAN_BITS'(v);
		px.idle_pct = pct;
		return px;
	endfunction

	function automatic int pick_channel();
		case ($urandom_range(5))
			0: return 0;
			1: return CHAN_MAX;
			default: return $urandom_range(CHAN_MAX);
		endcase
	endfunction

	initial begin
		int phase_pct[4];
		int h;
		int k;
		phase_pct = '{0, 48, 0, 36};

		// Directed: field extremes, sector edges, gray and wrapped hues.
		pixel_queue.push_back(make_pixel(0, 255, 255, 0));
		pixel_queue.push_back(make_pixel(0, 0, 0, 0));
		pixel_queue.push_back(make_pixel(0, 0, 255, 0));
		pixel_queue.push_back(make_pixel(0, 255, 0, 0));
		pixel_queue.push_back(make_pixel(TURN_SIZE - 1, 255, 255, 0));
		pixel_queue.push_back(make_pixel(-1, 255, 255, 0));
		pixel_queue.push_back(make_pixel(-1, 128, 200, 0));
		pixel_queue.push_back(make_pixel(-32768, 255, 255, 0));
		pixel_queue.push_back(make_pixel(32767, 255, 255, 0));
		pixel_queue.push_back(make_pixel(TURN_SIZE, 255, 255, 0));
		pixel_queue.push_back(make_pixel(SECTOR_SIZE - 1, 255, 255, 0));
		pixel_queue.push_back(make_pixel(SECTOR_SIZE, 255, 255, 0));
		pixel_queue.push_back(make_pixel(SECTOR_SIZE + 1, 200, 100, 0));
		for (k = 0; k < 6; k++)
			pixel_queue.push_back(make_pixel(k * SECTOR_SIZE + SECTOR_SIZE / 2, 255, 255, 0));
		pixel_queue.push_back(make_pixel(5 * SECTOR_SIZE + 17, 170, 85, 0));
		pixel_queue.push_back(make_pixel(2 * SECTOR_SIZE, 1, 254, 0));

		// Random: mostly in-range hues, plus gray, wrapped, edge and raw patterns.
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			case ($urandom_range(9))
				6: h = -$urandom_range(1, 32768);
				7: h = $urandom_range(TURN_SIZE, 32767);
				8: begin
					k = $urandom_range(6);
					h = k * SECTOR_SIZE + $urandom_range(2) - 1;
				end
				9: h = $urandom_range(16'hffff);
				default: h = $urandom_range(TURN_SIZE - 1);
			endcase
			pixel_queue.push_back(make_pixel(h, pick_channel(), pick_channel(),
				phase_pct[(i * 4) / RANDOM_PIXELS]));
		end

		while (pixel_queue.size() > 0 || start || rgb_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Converted %0d pixels, checked %0d results (%0d gray, %0d wrapped hues)",
			pixels_sent, results_seen, gray_count, wrap_count);
		$display("Sender idle phases at 0, 48 and 36 percent; %0d mismatches", error_count);
		if (error_count == 0 && rgb_expected.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[hsv_to_rgb_core.f]
rtl/core/hsvrgb_pkg.sv
rtl/core/hsvrgb_hue.sv
rtl/core/hsv_to_rgb_core.sv
bench/testbench.sv
